>>> sv/flvh_pkg.sv
package flvh_pkg;

  // Parse phases, one-hot.
  typedef enum logic [8:0] {
    PH_SIG      = 9'b000000001,
    PH_HDR      = 9'b000000010,
    PH_SKIPHDR  = 9'b000000100,
    PH_PREV     = 9'b000001000,
    PH_TAGHDR   = 9'b000010000,
    PH_VIDEO    = 9'b000100000,
    PH_AUDIO    = 9'b001000000,
    PH_SKIPBODY = 9'b010000000,
    PH_HALT     = 9'b100000000
  } phase_e;

  // Record kinds.
  localparam logic [2:0] KIND_FILE  = 3'd0;
  localparam logic [2:0] KIND_TAG   = 3'd1;
  localparam logic [2:0] KIND_VIDEO = 3'd2;
  localparam logic [2:0] KIND_AUDIO = 3'd3;
  localparam logic [2:0] KIND_ERR   = 3'd4;

  localparam logic [7:0]  SIG_BYTE0  = 8'h46;
  localparam logic [7:0]  SIG_BYTE1  = 8'h4c;
  localparam logic [7:0]  SIG_BYTE2  = 8'h56;
  localparam logic [7:0]  TAG_AUDIO  = 8'd8;
  localparam logic [7:0]  TAG_VIDEO  = 8'd9;
  localparam logic [3:0]  CODEC_AVC  = 4'd7;
  localparam logic [3:0]  FORMAT_AAC = 4'd10;
  localparam logic [31:0] HDR_LEN    = 32'd9;

  // Last byte index of each fixed-length section.
  localparam logic [3:0] SIG_LAST   = 4'd2;
  localparam logic [3:0] HDR_LAST   = 4'd5;
  localparam logic [3:0] PREV_LAST  = 4'd3;
  localparam logic [3:0] TAG_LAST   = 4'd10;
  localparam logic [3:0] VIDEO_LAST = 4'd4;
  localparam logic [3:0] AUDIO_LAST = 4'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  version_or_type;
    logic        has_audio;
    logic        has_video;
    logic [31:0] size_value;
    logic [31:0] tag_timestamp;
    logic [23:0] stream_number;
    logic [3:0]  codec_or_format;
    logic [3:0]  frame_or_audio_bits;
    logic [7:0]  packet_type;
    logic [23:0] comp_offset;
    logic [12:0] aac_config;
  } rec_t;

  function automatic logic [7:0] sig_byte(input logic [1:0] idx);
    logic [7:0] val;
    case (idx)
      2'd0:    val = SIG_BYTE0;
      2'd1:    val = SIG_BYTE1;
      2'd2:    val = SIG_BYTE2;
      default: val = 8'h00;
    endcase
    return val;
  endfunction

endpackage

>>> sv/flvh_parser.sv
module flvh_parser import flvh_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] data_i,
  input  logic       sof_i,
  output logic       emit_o,
  output rec_t       rec_o
);

  phase_e      phase_q, phase_d, ph_c;
  logic [3:0]  idx_q, idx_d, idx_c;
  logic [31:0] accum_q, accum_d, accum_c;
  logic [31:0] shadow_q, shadow_d, shadow_c;
  logic [31:0] skip_q, skip_d, skip_c;
  logic [7:0]  type_q, type_d, type_c;
  logic [23:0] size_q, size_d, size_c;
  logic [23:0] cons_q, cons_d, cons_c;
  logic [31:0] skip_dec;
  logic [23:0] cons_inc;
  logic [7:0]  head;
  logic        done;

  // A start-of-file byte is parsed from the reset state.
  always_comb begin
    if (sof_i) begin
      ph_c     = PH_SIG;
      idx_c    = '0;
      accum_c  = '0;
      shadow_c = '0;
      skip_c   = '0;
      type_c   = '0;
      size_c   = '0;
      cons_c   = '0;
    end else begin
      ph_c     = phase_q;
      idx_c    = idx_q;
      accum_c  = accum_q;
      shadow_c = shadow_q;
      skip_c   = skip_q;
      type_c   = type_q;
      size_c   = size_q;
      cons_c   = cons_q;
    end
  end

  assign skip_dec = skip_c - 32'd1;
  assign cons_inc = cons_c + 24'd1;

  always_comb begin
    phase_d  = ph_c;
    idx_d    = idx_c;
    accum_d  = accum_c;
    shadow_d = shadow_c;
    skip_d   = skip_c;
    type_d   = type_c;
    size_d   = size_c;
    cons_d   = cons_c;
    emit_o   = 1'b0;
    rec_o    = '0;
    head     = '0;
    done     = 1'b0;

    case (ph_c)
      PH_SIG: begin
        if (data_i != sig_byte(idx_c[1:0])) begin
          emit_o     = 1'b1;
          rec_o.kind = KIND_ERR;
          phase_d    = PH_HALT;
        end else if (idx_c == SIG_LAST) begin
          phase_d = PH_HDR;
          idx_d   = '0;
          accum_d = '0;
        end else begin
          idx_d = idx_c + 4'd1;
        end
      end

      PH_HDR: begin
        if (idx_c == 4'd0) begin
          shadow_d = {24'h0, data_i};
        end else if (idx_c == 4'd1) begin
          shadow_d = shadow_c | {16'h0, data_i, 8'h0};
        end else begin
          accum_d = {accum_c[23:0], data_i};
        end
        if (idx_c == HDR_LAST) begin
          emit_o                = 1'b1;
          rec_o.kind            = KIND_FILE;
          rec_o.version_or_type = shadow_d[7:0];
          rec_o.has_audio       = shadow_d[10];
          rec_o.has_video       = shadow_d[8];
          rec_o.size_value      = accum_d;
          // Offsets of nine or less leave nothing to skip.
          skip_d  = (accum_d > HDR_LEN) ? (accum_d - HDR_LEN) : '0;
          phase_d = (accum_d > HDR_LEN) ? PH_SKIPHDR : PH_PREV;
          idx_d   = '0;
        end else begin
          idx_d = idx_c + 4'd1;
        end
      end

      PH_SKIPHDR: begin
        skip_d = skip_dec;
        if (skip_dec == '0) begin
          phase_d = PH_PREV;
          idx_d   = '0;
        end
      end

      PH_PREV: begin
        if (idx_c == PREV_LAST) begin
          phase_d = PH_TAGHDR;
          idx_d   = '0;
        end else begin
          idx_d = idx_c + 4'd1;
        end
      end

      PH_TAGHDR: begin
        if (idx_c == 4'd0) begin
          type_d   = data_i;
          size_d   = '0;
          shadow_d = '0;
          accum_d  = '0;
        end else if (idx_c <= 4'd3) begin
          size_d = {size_c[15:0], data_i};
        end else if (idx_c <= 4'd6) begin
          shadow_d = {8'h0, shadow_c[15:0], data_i};
        end else if (idx_c == 4'd7) begin
          shadow_d = shadow_c | {data_i, 24'h0};
        end else begin
          accum_d = {8'h0, accum_c[15:0], data_i};
        end
        if (idx_c == TAG_LAST) begin
          emit_o                = 1'b1;
          rec_o.kind            = KIND_TAG;
          rec_o.version_or_type = type_d;
          rec_o.size_value      = {8'h0, size_d};
          rec_o.tag_timestamp   = shadow_d;
          rec_o.stream_number   = accum_d[23:0];
          cons_d   = '0;
          idx_d    = '0;
          shadow_d = '0;
          accum_d  = '0;
          if (size_d == '0) begin
            phase_d = PH_PREV;
          end else if (type_d == TAG_VIDEO) begin
            phase_d = PH_VIDEO;
          end else if (type_d == TAG_AUDIO) begin
            phase_d = PH_AUDIO;
          end else begin
            phase_d = PH_SKIPBODY;
          end
        end else begin
          idx_d = idx_c + 4'd1;
        end
      end

      PH_VIDEO, PH_AUDIO: begin
        if (idx_c == 4'd0) begin
          shadow_d = {24'h0, data_i};
        end else if (idx_c == 4'd1) begin
          shadow_d = shadow_c | {16'h0, data_i, 8'h0};
        end else begin
          accum_d = {8'h0, accum_c[15:0], data_i};
        end
        head = shadow_d[7:0];
        if (ph_c == PH_VIDEO) begin
          done = ((idx_c == 4'd0) && (head[3:0] != CODEC_AVC)) || (idx_c == VIDEO_LAST);
        end else begin
          done = ((idx_c == 4'd0) && (head[7:4] != FORMAT_AAC)) ||
                 ((idx_c == 4'd1) && (shadow_d[15:8] != 8'h0)) ||
                 (idx_c == AUDIO_LAST);
        end
        if (done) begin
          emit_o            = 1'b1;
          rec_o.packet_type = (idx_c != 4'd0) ? shadow_d[15:8] : 8'h0;
          if (ph_c == PH_VIDEO) begin
            rec_o.kind                = KIND_VIDEO;
            rec_o.codec_or_format     = head[3:0];
            rec_o.frame_or_audio_bits = head[7:4];
            if (idx_c == VIDEO_LAST) begin
              rec_o.comp_offset = accum_d[23:0];
            end
          end else begin
            rec_o.kind                = KIND_AUDIO;
            rec_o.codec_or_format     = head[7:4];
            rec_o.frame_or_audio_bits = head[3:0];
            if (idx_c == AUDIO_LAST) begin
              // Object type, sample rate index and channel count of the AAC config.
              rec_o.aac_config = {accum_d[15:11], accum_d[10:8], accum_d[7], accum_d[6:3]};
            end
          end
          phase_d = PH_SKIPBODY;
        end
        idx_d  = idx_c + 4'd1;
        cons_d = cons_inc;
        // A body that ends early drops the unfinished record.
        if (cons_inc >= size_c) begin
          phase_d = PH_PREV;
          idx_d   = '0;
        end
      end

      PH_SKIPBODY: begin
        cons_d = cons_inc;
        if (cons_inc >= size_c) begin
          phase_d = PH_PREV;
          idx_d   = '0;
        end
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_SIG;
      idx_q    <= '0;
      accum_q  <= '0;
      shadow_q <= '0;
      skip_q   <= '0;
      type_q   <= '0;
      size_q   <= '0;
      cons_q   <= '0;
    end else if (fire_i) begin
      phase_q  <= phase_d;
      idx_q    <= idx_d;
      accum_q  <= accum_d;
      shadow_q <= shadow_d;
      skip_q   <= skip_d;
      type_q   <= type_d;
      size_q   <= size_d;
      cons_q   <= cons_d;
    end
  end

endmodule

>>> sv/flvh_out_reg.sv
module flvh_out_reg import flvh_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic load_i,
  input  rec_t rec_i,
  input  logic stall_i,
  output logic ready_o,
  output logic valid_o,
  output rec_t rec_o
);

  logic valid_q;
  rec_t rec_q;

  // The register can take a record when it is empty or being emptied.
  assign ready_o = !valid_q || !stall_i;
  assign valid_o = valid_q;
  assign rec_o   = rec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (!stall_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      rec_q <= rec_i;
    end
  end

endmodule

>>> sv/flv_container_header_parser_top.sv
// FLV header parser. The input channel carries one stream byte per request on
// data_byte_i, with start_of_file_i marking the first byte of a new file; the
// output channel carries one record per request (file header, tag header, video
// info, audio info or signature error). Both channels use valid and stall: a
// request moves on a rising edge with valid high and stall low.
// Throughput is one byte per cycle unless in_stall_o holds a byte back. A byte
// is held in an input register and parsed by the phase logic, and its record, if
// any, is loaded into the output register, which drives the outputs.
// Most bytes produce no record; they pass through the parser even while the
// output register holds a record that the receiver stalls. A byte that produces
// a record waits in the input register until the output register frees, and
// in_stall_o then rises until that happens.
// Reset empties both registers and puts the parser in front of the signature.
// A start-of-file byte restarts the parse at any point; after a signature error
// all bytes are dropped until the next start of file.
module flv_container_header_parser_top import flvh_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  data_byte_i,
  input  logic        start_of_file_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  record_kind_o,
  output logic [7:0]  version_or_type_o,
  output logic        has_audio_o,
  output logic        has_video_o,
  output logic [31:0] size_value_o,
  output logic [31:0] tag_timestamp_o,
  output logic [23:0] stream_number_o,
  output logic [3:0]  codec_or_format_o,
  output logic [3:0]  frame_or_audio_bits_o,
  output logic [7:0]  packet_type_o,
  output logic [23:0] comp_offset_o,
  output logic [12:0] aac_config_o
);

  logic       in_valid_q;
  logic [7:0] data_q;
  logic       sof_q;
  logic       accept;
  logic       fire;
  logic       emit;
  logic       out_ready;
  rec_t       rec_w;
  rec_t       rec_out;

  assign fire       = in_valid_q && (!emit || out_ready);
  assign in_stall_o = in_valid_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= data_byte_i;
      sof_q  <= start_of_file_i;
    end
  end

  flvh_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .data_i (data_q),
    .sof_i  (sof_q),
    .emit_o (emit),
    .rec_o  (rec_w)
  );

  flvh_out_reg u_out_reg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (fire && emit),
    .rec_i   (rec_w),
    .stall_i (out_stall_i),
    .ready_o (out_ready),
    .valid_o (out_valid_o),
    .rec_o   (rec_out)
  );

  assign record_kind_o         = rec_out.kind;
  assign version_or_type_o     = rec_out.version_or_type;
  assign has_audio_o           = rec_out.has_audio;
  assign has_video_o           = rec_out.has_video;
  assign size_value_o          = rec_out.size_value;
  assign tag_timestamp_o       = rec_out.tag_timestamp;
  assign stream_number_o       = rec_out.stream_number;
  assign codec_or_format_o     = rec_out.codec_or_format;
  assign frame_or_audio_bits_o = rec_out.frame_or_audio_bits;
  assign packet_type_o         = rec_out.packet_type;
  assign comp_offset_o         = rec_out.comp_offset;
  assign aac_config_o          = rec_out.aac_config;

  // An accepted byte always lands in the input register.
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_valid_q)
    else $error("accepted byte not held in input register");

  // A record that the receiver stalls is not overwritten by the next one.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && emit && out_valid_o && out_stall_i) |=>
    (out_valid_o && $stable(rec_out)))
    else $error("pending record overwritten");

  // The input only stalls while a byte waits in the input register.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && emit && !out_ready))
    else $error("input stalled without a blocked record");

  // Only defined record kinds reach the outputs.
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (record_kind_o <= KIND_ERR))
    else $error("undefined record kind on output");

endmodule
